### rtl/abet_pkg.sv
// ----------------------------------------------------------------------------
// Audio block envelope tracker package
// Shared widths, constants, payload types and sample helpers.
// ----------------------------------------------------------------------------
package abet_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 48;
  localparam int PEAK_BITS   = SAMPLE_BITS - 1;
  localparam int CFG_BITS    = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0]   wide_sum_t;
  typedef logic [PEAK_BITS-1:0]          peak_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [CFG_BITS-1:0]           chan_cfg_t;

  localparam sample_t   SMAX       = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t   SNEG_LIMIT = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
  localparam chan_cfg_t CH_MONO    = chan_cfg_t'(1);
  localparam chan_cfg_t CH_STEREO  = chan_cfg_t'(2);

  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
    logic    block_end;
    logic    clear_interval;
  } in_data_t;

  typedef struct packed {
    count_t  first_frame;
    count_t  next_frame;
    sample_t left_min;
    sample_t left_max;
    sample_t right_min;
    sample_t right_max;
    sample_t mix_min;
    sample_t mix_max;
    peak_t   session_peak;
    peak_t   window_peak;
  } out_data_t;

  typedef struct packed {
    sample_t smp;
    sample_t min_v;
    sample_t max_v;
    peak_t   peak;
  } lane_res_t;

  typedef struct packed {
    logic acc;
    logic block_end;
    logic clear;
    logic mono;
  } frame_ctrl_t;

  function automatic sample_t clamp_sample(sample_t s);
    sample_t r;
    r = (s == SNEG_LIMIT) ? -SMAX : s;
    return r;
  endfunction

  function automatic peak_t magnitude(sample_t s);
    sample_t a;
    a = (s < 0) ? -s : s;
    return a[PEAK_BITS-1:0];
  endfunction

endpackage

### rtl/audio_block_envelope_tracker.sv
// A record is presented in the cycle after the transfer of its block-ending frame.
// Throughput: one frame per cycle; frames that do not end a block are always taken.
// A block-ending frame waits only while the previous record is unread and not taken.
// Reset: synchronous, active low; clears counters, extremes and peak holds; selects stereo mode.
// While reset is held the input is not ready.
// ----------------------------------------------------------------------------
// Audio block envelope tracker
// Left, right and mix lanes track block extremes side by side; a merge stage
// forms the envelope record with frame range and peak holds.
// ----------------------------------------------------------------------------
module audio_block_envelope_tracker
  import abet_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  chan_cfg_t cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_data_t out_data
);

  chan_cfg_t   chan_r;
  logic        mono;
  logic        acc;
  lane_res_t   left_res, right_res, mix_res;
  wide_sum_t   mix_sum;
  sample_t     mix_smp;
  frame_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= CH_STEREO;
    end else if (cfg_we) begin
      chan_r <= cfg_wdata;
    end
  end

  assign mono     = (chan_r == CH_MONO);
  assign in_ready = rst_n && (!out_valid || out_ready || !in_data.block_end);
  assign acc      = in_valid && in_ready;

  always_comb begin
    mix_sum = wide_sum_t'(left_res.smp) + wide_sum_t'(right_res.smp);
    mix_smp = mono ? left_res.smp : mix_sum[SAMPLE_BITS:1];
  end

  assign ctrl = '{acc: acc, block_end: in_data.block_end,
                  clear: in_data.clear_interval, mono: mono};

  abet_lane u_left (
    .clk(clk), .rst_n(rst_n), .acc(acc), .fold_en(1'b1),
    .restart(in_data.block_end), .sample_in(in_data.left_sample), .res(left_res)
  );

  abet_lane u_right (
    .clk(clk), .rst_n(rst_n), .acc(acc), .fold_en(!mono),
    .restart(in_data.block_end), .sample_in(in_data.right_sample), .res(right_res)
  );

  abet_lane u_mix (
    .clk(clk), .rst_n(rst_n), .acc(acc), .fold_en(1'b1),
    .restart(in_data.block_end), .sample_in(mix_smp), .res(mix_res)
  );

  abet_merge u_merge (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .left_res(left_res), .right_res(right_res), .mix_res(mix_res),
    .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

### rtl/abet_lane.sv
// ----------------------------------------------------------------------------
// Envelope lane
// Clamps one sample stream and tracks its block minimum, maximum and peak.
// ----------------------------------------------------------------------------
module abet_lane
  import abet_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  logic      fold_en,
  input  logic      restart,
  input  sample_t   sample_in,
  output lane_res_t res
);

  sample_t min_r, min_nxt;
  sample_t max_r, max_nxt;
  peak_t   peak_r, peak_nxt;
  sample_t smp;
  peak_t   mag;

  always_comb begin
    smp      = clamp_sample(sample_in);
    mag      = magnitude(smp);
    min_nxt  = (fold_en && (smp < min_r)) ? smp : min_r;
    max_nxt  = (fold_en && (smp > max_r)) ? smp : max_r;
    peak_nxt = (fold_en && (mag > peak_r)) ? mag : peak_r;
  end

  assign res = '{smp: smp, min_v: min_nxt, max_v: max_nxt, peak: peak_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= SMAX;
      max_r  <= -SMAX;
      peak_r <= '0;
    end else if (acc) begin
      if (restart) begin
        min_r  <= SMAX;
        max_r  <= -SMAX;
        peak_r <= '0;
      end else begin
        min_r  <= min_nxt;
        max_r  <= max_nxt;
        peak_r <= peak_nxt;
      end
    end
  end

endmodule

### rtl/abet_merge.sv
// ----------------------------------------------------------------------------
// Envelope merge stage
// Combines the lane extremes, keeps frame count and peak holds, and registers
// the envelope record.
// ----------------------------------------------------------------------------
module abet_merge
  import abet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  frame_ctrl_t ctrl,
  input  lane_res_t   left_res,
  input  lane_res_t   right_res,
  input  lane_res_t   mix_res,
  input  logic        out_ready,
  output logic        out_valid,
  output out_data_t   out_data
);

  count_t    frame_r, frame_nxt;
  count_t    start_r;
  peak_t     hold_r, hold_nxt;
  peak_t     window_r, window_nxt;
  peak_t     block_peak;
  peak_t     window_base;
  logic      out_valid_r;
  out_data_t out_r, out_nxt;
  logic      emit;

  always_comb begin
    emit        = ctrl.acc && ctrl.block_end;
    frame_nxt   = frame_r + count_t'(1);
    block_peak  = (left_res.peak > right_res.peak) ? left_res.peak : right_res.peak;
    hold_nxt    = (block_peak > hold_r) ? block_peak : hold_r;
    window_base = ctrl.clear ? '0 : window_r;
    window_nxt  = window_base;
    if (ctrl.block_end && (block_peak > window_base)) begin
      window_nxt = block_peak;
    end
    out_nxt.first_frame  = start_r;
    out_nxt.next_frame   = frame_nxt;
    out_nxt.left_min     = left_res.min_v;
    out_nxt.left_max     = left_res.max_v;
    out_nxt.right_min    = ctrl.mono ? '0 : right_res.min_v;
    out_nxt.right_max    = ctrl.mono ? '0 : right_res.max_v;
    out_nxt.mix_min      = mix_res.min_v;
    out_nxt.mix_max      = mix_res.max_v;
    out_nxt.session_peak = hold_nxt;
    out_nxt.window_peak  = window_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      start_r     <= '0;
      hold_r      <= '0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.acc) begin
        frame_r  <= frame_nxt;
        window_r <= window_nxt;
        if (ctrl.block_end) begin
          start_r <= frame_nxt;
          hold_r  <= hold_nxt;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_window_below_session: assert property (@(posedge clk) disable iff (!rst_n)
    window_r <= hold_r)
    else $error("interval peak exceeds session peak");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("record overwritten before transfer");

  a_drop_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !emit) |=> !out_valid_r)
    else $error("record repeated after transfer");

  a_mix_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_r.mix_min) <= $signed(out_r.mix_max)))
    else $error("mix extremes out of order");

  a_left_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_r.left_min) <= $signed(out_r.left_max)))
    else $error("left extremes out of order");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio block envelope tracker testbench
// Sends audio frames in mono and stereo modes and tracks the block extremes,
// frame range and peak holds alongside the design. Each envelope record is
// checked field by field against the oldest predicted record. Both ends stall
// at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import abet_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int DRAIN_PAD = 6;
  localparam int LONG_HOLD = 400;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int MAX_REPORTS = 10;

  localparam chan_cfg_t CH_ALIAS_ZERO = chan_cfg_t'(0);
  localparam chan_cfg_t CH_ALIAS_THREE = chan_cfg_t'(3);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  chan_cfg_t cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_data_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_data_t out_data;

  in_data_t frames_to_send[$];
  out_data_t records_due[$];
  int mismatches = 0;

  bit src_lazy = 1'b1;
  bit sink_lazy = 1'b1;
  bit hold_req = 1'b0;
  int src_gap = 0;
  int sink_wait = 0;
  int hold_left = 0;
  bit hold_armed = 1'b0;

  chan_cfg_t chan_mode;
  count_t frame_cnt;
  count_t blk_start;
  sample_t ch_min[2];
  sample_t ch_max[2];
  sample_t mx_min;
  sample_t mx_max;
  peak_t blk_peak;
  peak_t sess_peak;
  peak_t win_peak;

  audio_block_envelope_tracker i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic sample_t limit_sample(sample_t s);
    return (s < -SMAX) ? -SMAX : s;
  endfunction

  function automatic peak_t abs_level(sample_t s);
    return peak_t'((s < 0) ? -s : s);
  endfunction

  function automatic void clear_extremes();
    ch_min[0] = SMAX;
    ch_min[1] = SMAX;
    ch_max[0] = -SMAX;
    ch_max[1] = -SMAX;
    mx_min = SMAX;
    mx_max = -SMAX;
    blk_peak = '0;
  endfunction

  function automatic void track_lane(int ch, sample_t s);
    if (s < ch_min[ch]) ch_min[ch] = s;
    if (s > ch_max[ch]) ch_max[ch] = s;
    if (abs_level(s) > blk_peak) blk_peak = abs_level(s);
  endfunction

  function automatic void fold_frame(in_data_t f);
    sample_t l;
    sample_t r;
    sample_t mix;
    logic signed [SAMPLE_BITS:0] sum;
    logic signed [SAMPLE_BITS:0] half;
    logic mono;
    out_data_t rec;
    mono = (chan_mode == CH_MONO);
    l = limit_sample(f.left_sample);
    r = limit_sample(f.right_sample);
    track_lane(0, l);
    if (mono) begin
      mix = l;
    end else begin
      track_lane(1, r);
      sum = l + r;
      half = sum >>> 1;
      mix = half[SAMPLE_BITS-1:0];
    end
    if (mix < mx_min) mx_min = mix;
    if (mix > mx_max) mx_max = mix;
    frame_cnt = frame_cnt + 1'b1;
    if (f.clear_interval) win_peak = '0;
    if (f.block_end) begin
      if (blk_peak > sess_peak) sess_peak = blk_peak;
      if (blk_peak > win_peak) win_peak = blk_peak;
      rec.first_frame = blk_start;
      rec.next_frame = frame_cnt;
      rec.left_min = ch_min[0];
      rec.left_max = ch_max[0];
      rec.right_min = mono ? sample_t'(0) : ch_min[1];
      rec.right_max = mono ? sample_t'(0) : ch_max[1];
      rec.mix_min = mx_min;
      rec.mix_max = mx_max;
      rec.session_peak = sess_peak;
      rec.window_peak = win_peak;
      records_due = {records_due, rec};
      blk_start = frame_cnt;
      clear_extremes();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("Mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  function automatic void check_record(out_data_t got);
    out_data_t want;
    if (records_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("Unexpected envelope record: %0h", got);
      return;
    end
    want = records_due.pop_front();
    check_field("first_frame", 64'(want.first_frame), 64'(got.first_frame));
    check_field("next_frame", 64'(want.next_frame), 64'(got.next_frame));
    check_field("left_min", 64'(want.left_min), 64'(got.left_min));
    check_field("left_max", 64'(want.left_max), 64'(got.left_max));
    check_field("right_min", 64'(want.right_min), 64'(got.right_min));
    check_field("right_max", 64'(want.right_max), 64'(got.right_max));
    check_field("mix_min", 64'(want.mix_min), 64'(got.mix_min));
    check_field("mix_max", 64'(want.mix_max), 64'(got.mix_max));
    check_field("session_peak", 64'(want.session_peak), 64'(got.session_peak));
    check_field("window_peak", 64'(want.window_peak), 64'(got.window_peak));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) fold_frame(in_data);
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (frames_to_send.size() > 0) begin
        in_data <= frames_to_send.pop_front();
        in_valid <= 1'b1;
        src_gap <= src_lazy ? $urandom_range(0, 3) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : sink_side
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) check_record(out_data);
      if (hold_req && !hold_armed) begin
        hold_armed <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_valid && out_ready) begin
        w = sink_lazy ? $urandom_range(0, 3) : 0;
        sink_wait <= w;
        out_ready <= (w == 0);
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        out_ready <= (sink_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic sample_t pick_sample();
    sample_t v;
    case ($urandom_range(0, 31))
      0: v = SNEG_LIMIT;
      1: v = SMAX;
      2: v = -SMAX;
      3, 4, 5: v = sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: begin
        v = sample_t'($urandom);
        v = v >>> $urandom_range(0, SAMPLE_BITS - 1);
      end
    endcase
    return v;
  endfunction

  task automatic push_frame(sample_t l, sample_t r, logic last, logic clr);
    in_data_t f;
    f.left_sample = l;
    f.right_sample = r;
    f.block_end = last;
    f.clear_interval = clr;
    frames_to_send = {frames_to_send, f};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || records_due.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_mode(chan_cfg_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    chan_mode = v;
    @(negedge clk);
  endtask

  // Blocks of random length; an open block at the end carries across the
  // next mode change.
  task automatic queue_blocks(int n_frames, int max_len, bit close_last);
    int left_in_block;
    logic last;
    left_in_block = $urandom_range(1, max_len);
    for (int i = 0; i < n_frames; i++) begin
      last = (left_in_block == 1);
      if (i == n_frames - 1) last = close_last;
      push_frame(pick_sample(), pick_sample(), last, $urandom_range(0, 7) == 0);
      left_in_block--;
      if (left_in_block == 0) left_in_block = $urandom_range(1, max_len);
    end
  endtask

  initial begin : stimulus
    chan_cfg_t mode_list[4];
    mode_list = '{CH_MONO, CH_STEREO, CH_ALIAS_ZERO, CH_ALIAS_THREE};
    chan_mode = CH_STEREO;
    frame_cnt = '0;
    blk_start = '0;
    sess_peak = '0;
    win_peak = '0;
    clear_extremes();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_frame(SMAX, SNEG_LIMIT, 1'b1, 1'b0);
    push_frame(SNEG_LIMIT, SMAX, 1'b1, 1'b0);
    push_frame(-1, 0, 1'b0, 1'b0);
    push_frame(0, 0, 1'b1, 1'b0);
    push_frame(1, 0, 1'b1, 1'b1);
    push_frame(1000, -3, 1'b0, 1'b1);
    push_frame(-5, 7, 1'b1, 1'b0);
    push_frame(SMAX, SMAX, 1'b0, 1'b0);
    push_frame(-SMAX, -SMAX, 1'b1, 1'b0);
    push_frame(0, 0, 1'b1, 1'b0);
    wait_drained();

    write_mode(CH_MONO);
    push_frame(100, SNEG_LIMIT, 1'b1, 1'b0);
    push_frame(SNEG_LIMIT, 5, 1'b0, 1'b0);
    push_frame(7, SMAX, 1'b1, 1'b1);
    push_frame(-9, 3, 1'b0, 1'b0);
    wait_drained();
    write_mode(CH_STEREO);
    push_frame(4, -8, 1'b1, 1'b0);
    push_frame(2, -2, 1'b0, 1'b0);
    wait_drained();
    write_mode(CH_MONO);
    push_frame(3, 3, 1'b1, 1'b0);
    wait_drained();
    write_mode(CH_ALIAS_ZERO);
    push_frame(5, -6, 1'b1, 1'b0);
    wait_drained();
    write_mode(CH_ALIAS_THREE);
    push_frame(-5, 6, 1'b1, 1'b0);
    push_frame(SMAX, 1, 1'b1, 1'b1);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      if (p < 4) write_mode(mode_list[p]);
      else write_mode(mode_list[$urandom_range(0, 3)]);
      src_lazy = ($urandom_range(0, 3) != 0);
      sink_lazy = ($urandom_range(0, 3) != 0);
      if (p == 5) begin
        src_lazy = 1'b0;
        hold_req = 1'b1;
        queue_blocks(100, 2, 1'b1);
      end else begin
        queue_blocks(100, $urandom_range(1, 12), $urandom_range(0, 3) != 0);
      end
      wait_drained();
    end

    if (mismatches == 0 && records_due.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
